FILE: rtl/core/pld_pkg.sv
package pld_pkg;

  localparam int NumSteps = 64;
  localparam int NumBytes = 16;

  typedef struct packed {
    logic        action;
    logic        is_signed;
    logic [1:0]  lane_size;
    logic [63:0] dividend_lo;
    logic [63:0] dividend_hi;
    logic [63:0] divisor_lo;
    logic [63:0] divisor_hi;
  } pld_req_t;

  typedef struct packed {
    logic [63:0] result_lo;
    logic [63:0] result_hi;
    logic [15:0] zero_divisor_lanes;
    logic [15:0] overflow_lanes;
  } pld_rsp_t;

  // per-item control carried alongside the datapath
  typedef struct packed {
    logic        rem;
    logic [1:0]  size;
    logic [15:0] neg_q;
    logic [15:0] neg_r;
    logic [15:0] zf;
    logic [15:0] of;
  } pld_ctl_t;

  typedef struct packed {
    pld_ctl_t     ctl;
    logic [127:0] num;
    logic [127:0] den;
  } pld_job_t;

  typedef struct packed {
    logic [127:0] r;
    logic [127:0] q;
  } pld_rq_t;

  // two's complement negate of the lanes whose bytes are selected
  function automatic logic [127:0] lane_neg(logic [127:0] x, logic [15:0] sel,
                                             logic [1:0] sz);
    logic [127:0] y;
    logic         c;
    logic [8:0]   s;
    int           lmask;
    y = x;
    c = 1'b0;
    lmask = (1 << sz) - 1;
    for (int j = 0; j < NumBytes; j++) begin
      if ((j & lmask) == 0) c = 1'b1;
      s = {1'b0, ~x[8*j +: 8]} + {8'd0, c};
      c = s[8];
      if (sel[j]) y[8*j +: 8] = s[7:0];
    end
    return y;
  endfunction

  // one restoring division step in every lane
  function automatic pld_rq_t div_step(logic [127:0] r, logic [127:0] q, logic [127:0] d,
                                       logic [1:0] sz, logic en);
    pld_rq_t      o;
    logic [127:0] rs;
    logic [127:0] qs;
    logic [127:0] df;
    logic [15:0]  bo;
    logic         b;
    logic         ok;
    logic [8:0]   t;
    int           lmask;
    int           w;
    int           jt;
    lmask = (1 << sz) - 1;
    w = 8 << sz;
    rs = r << 1;
    qs = q << 1;
    b = 1'b0;
    for (int j = 0; j < NumBytes; j++) begin
      if ((j & lmask) == 0) begin
        rs[8*j] = q[8*j + w - 1];
        qs[8*j] = 1'b0;
        b = 1'b0;
      end
      t = {1'b0, rs[8*j +: 8]} - {1'b0, d[8*j +: 8]} - {8'd0, b};
      bo[j] = t[8];
      df[8*j +: 8] = t[7:0];
      b = t[8];
    end
    o.r = r;
    o.q = q;
    if (en) begin
      for (int j = 0; j < NumBytes; j++) begin
        jt = (j & ~lmask) + lmask;
        ok = r[8*jt + 7] | ~bo[jt];
        o.r[8*j +: 8] = ok ? df[8*j +: 8] : rs[8*j +: 8];
        o.q[8*j +: 8] = qs[8*j +: 8];
        if (((j & lmask) == 0) && ok) o.q[8*j] = 1'b1;
      end
    end
    return o;
  endfunction

endpackage

FILE: rtl/core/pld_front.sv
module pld_front (
  input  pld_pkg::pld_req_t req_i,
  output pld_pkg::pld_job_t job_o
);
  import pld_pkg::*;

  logic [127:0] a, b;
  logic [15:0]  az, a80, bz, bff;
  logic [15:0]  na, nb, zf, of;
  logic [15:0]  neg_a, neg_b, neg_q;
  logic [1:0]   sz;
  logic         zl, ol;
  int           lmask;

  always_comb begin
    sz = req_i.lane_size;
    lmask = (1 << sz) - 1;
    a = {req_i.dividend_hi, req_i.dividend_lo};
    b = {req_i.divisor_hi, req_i.divisor_lo};
    for (int j = 0; j < NumBytes; j++) begin
      az[j]  = (a[8*j +: 8] == 8'h00);
      a80[j] = (a[8*j +: 8] == 8'h80);
      bz[j]  = (b[8*j +: 8] == 8'h00);
      bff[j] = (b[8*j +: 8] == 8'hff);
    end
    for (int k = 0; k < NumBytes; k++) begin
      zl = 1'b1;
      ol = req_i.is_signed;
      na[k] = 1'b0;
      nb[k] = 1'b0;
      for (int j = 0; j < NumBytes; j++) begin
        if ((j >> sz) == k) begin
          zl = zl & bz[j];
          ol = ol & bff[j] & (((j & lmask) == lmask) ? a80[j] : az[j]);
          if ((j & lmask) == lmask) begin
            na[k] = req_i.is_signed & a[8*j + 7];
            nb[k] = req_i.is_signed & b[8*j + 7];
          end
        end
      end
      zf[k] = (k < (16 >> sz)) & zl;
      of[k] = (k < (16 >> sz)) & ol;
    end
    for (int j = 0; j < NumBytes; j++) begin
      neg_a[j] = na[j >> sz];
      neg_b[j] = nb[j >> sz];
      neg_q[j] = (na[j >> sz] ^ nb[j >> sz]) & ~zf[j >> sz];
    end
    job_o.ctl.rem   = req_i.action;
    job_o.ctl.size  = sz;
    job_o.ctl.neg_q = neg_q;
    job_o.ctl.neg_r = neg_a;
    job_o.ctl.zf    = zf;
    job_o.ctl.of    = of;
    job_o.num = lane_neg(a, neg_a, sz);
    job_o.den = lane_neg(b, neg_b, sz);
  end

endmodule

FILE: rtl/core/pld_queue.sv
module pld_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pld_pkg::pld_job_t data_i,
  output logic              full_o,
  output logic              valid_o,
  output pld_pkg::pld_job_t data_o
);
  import pld_pkg::*;

  pld_job_t   mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign pop     = valid_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/core/pld_back.sv
module pld_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  pld_pkg::pld_job_t job_i,
  output logic              done_o,
  output pld_pkg::pld_rsp_t rsp_o
);
  import pld_pkg::*;

  logic         vld_q [NumSteps+1];
  pld_ctl_t     ctl_q [NumSteps+1];
  logic [127:0] r_q   [NumSteps+1];
  logic [127:0] q_q   [NumSteps+1];
  logic [127:0] d_q   [NumSteps+1];
  logic         done_q;
  pld_rsp_t     rsp_q, rsp_d;
  logic [127:0] res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ctl_q[0] <= job_i.ctl;
    r_q[0]   <= '0;
    q_q[0]   <= job_i.num;
    d_q[0]   <= job_i.den;
  end

  for (genvar s = 0; s < NumSteps; s++) begin : g_step
    logic    en;
    pld_rq_t nx;

    always_comb begin
      en = (s >= NumSteps - (8 << ctl_q[s].size));
      nx = div_step(r_q[s], q_q[s], d_q[s], ctl_q[s].size, en);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      ctl_q[s+1] <= ctl_q[s];
      r_q[s+1]   <= nx.r;
      q_q[s+1]   <= nx.q;
      d_q[s+1]   <= d_q[s];
    end
  end

  always_comb begin
    if (ctl_q[NumSteps].rem) begin
      res = lane_neg(r_q[NumSteps], ctl_q[NumSteps].neg_r, ctl_q[NumSteps].size);
    end else begin
      res = lane_neg(q_q[NumSteps], ctl_q[NumSteps].neg_q, ctl_q[NumSteps].size);
    end
    rsp_d.result_lo          = res[63:0];
    rsp_d.result_hi          = res[127:64];
    rsp_d.zero_divisor_lanes = ctl_q[NumSteps].zf;
    rsp_d.overflow_lanes     = ctl_q[NumSteps].of;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[NumSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

FILE: rtl/core/packed_lane_divider.sv
// Lane-wise divider for 128-bit packed vectors of 8, 16, 32 or 64-bit lanes, signed or
// unsigned, returning quotient or remainder per word. A new word is taken every cycle
// while busy is low; busy only rises if the input queue fills, which cannot happen,
// as the queue pops whenever it holds a word. Each result passes through the queue,
// the divider input register, the 64-step pipelined restoring divider and the
// output register. It is valid for one cycle with done_o high.
// The receiver cannot stall the block.
module packed_lane_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  pld_pkg::pld_req_t req_i,
  output logic              done_o,
  output pld_pkg::pld_rsp_t rsp_o
);
  import pld_pkg::*;

  pld_job_t job_in, job_out;
  logic     full, q_valid;

  assign busy = full;

  pld_front u_front (
    .req_i (req_i),
    .job_o (job_in)
  );

  pld_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (start & ~full),
    .data_i  (job_in),
    .full_o  (full),
    .valid_o (q_valid),
    .data_o  (job_out)
  );

  pld_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .job_i   (job_out),
    .done_o  (done_o),
    .rsp_o   (rsp_o)
  );

endmodule

FILE: verif/pld_checker.sv
`timescale 1ns / 100ps

module pld_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              busy,
  input  pld_pkg::pld_req_t req_i,
  input  logic              done_o,
  input  pld_pkg::pld_rsp_t rsp_o,
  output int                fail_count,
  output int                pending_count
);
  import pld_pkg::*;

  pld_rsp_t expected_q[$];
  int       word_count;

  function automatic logic [63:0] divide_lane(logic [63:0] a, logic [63:0] b, int w,
                                              logic sg, logic rem, output logic zf,
                                              output logic of);
    logic [63:0] mask;
    logic [63:0] sign;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] q;
    logic [63:0] r;
    logic        na;
    logic        nb;
    mask = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
    sign = 64'd1 << (w - 1);
    a &= mask;
    b &= mask;
    zf = 1'b0;
    of = 1'b0;
    if (b == 0) begin
      zf = 1'b1;
      return rem ? a : mask;
    end
    if (sg) begin
      na = (a & sign) != 0;
      nb = (b & sign) != 0;
      ma = na ? ((64'd0 - a) & mask) : a;
      mb = nb ? ((64'd0 - b) & mask) : b;
      q = ma / mb;
      r = ma % mb;
      if (na != nb) q = (64'd0 - q) & mask;
      if (na) r = (64'd0 - r) & mask;
      of = (a == sign) && (b == mask);
    end else begin
      q = a / b;
      r = a % b;
    end
    return (rem ? r : q) & mask;
  endfunction

  function automatic pld_rsp_t divide_vector(pld_req_t rq);
    pld_rsp_t     o;
    logic [127:0] x;
    logic [127:0] y;
    logic [127:0] z;
    logic [63:0]  v;
    logic         zf;
    logic         of;
    int           w;
    int           n;
    w = 8 << rq.lane_size;
    n = 128 / w;
    x = {rq.dividend_hi, rq.dividend_lo};
    y = {rq.divisor_hi, rq.divisor_lo};
    z = '0;
    o = '0;
    for (int k = 0; k < n; k++) begin
      v = divide_lane(x[k*w +: 64] & ((w == 64) ? '1 : ((64'd1 << w) - 1)),
                      y[k*w +: 64] & ((w == 64) ? '1 : ((64'd1 << w) - 1)),
                      w, rq.is_signed, rq.action, zf, of);
      for (int b = 0; b < 64; b++) if (b < w) z[k*w + b] = v[b];
      o.zero_divisor_lanes[k] = zf;
      o.overflow_lanes[k] = of;
    end
    o.result_lo = z[63:0];
    o.result_hi = z[127:64];
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch word %0d %s: got %h want %h", word_count, what, got, want);
    fail_count++;
  endtask

  assign pending_count = expected_q.size();

  initial fail_count = 0;
  initial word_count = 0;

  always @(posedge clk_i) begin
    pld_rsp_t e;
    if (rst_ni) begin
      if (start && !busy) expected_q.push_back(divide_vector(req_i));
      if (done_o) begin
        if (expected_q.size() == 0) begin
          $display("unexpected result word");
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          if (rsp_o.result_lo !== e.result_lo)
            report_mismatch("result_lo", rsp_o.result_lo, e.result_lo);
          if (rsp_o.result_hi !== e.result_hi)
            report_mismatch("result_hi", rsp_o.result_hi, e.result_hi);
          if (rsp_o.zero_divisor_lanes !== e.zero_divisor_lanes)
            report_mismatch("zero_divisor_lanes", {48'd0, rsp_o.zero_divisor_lanes},
                            {48'd0, e.zero_divisor_lanes});
          if (rsp_o.overflow_lanes !== e.overflow_lanes)
            report_mismatch("overflow_lanes", {48'd0, rsp_o.overflow_lanes},
                            {48'd0, e.overflow_lanes});
          word_count++;
        end
      end
    end
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import pld_pkg::*;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  pld_req_t req_i;
  logic     done_o;
  pld_rsp_t rsp_o;
  int       fail_count;
  int       pending_count;
  int       idle_cycles;
  int       sent;

  localparam int Latency = 67;
  localparam int IdleLimit = 2000;

  packed_lane_divider u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  pld_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_i        (req_i),
    .done_o       (done_o),
    .rsp_o        (rsp_o),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // lane-patterned operand: each lane picks zero, one, all ones, min, max or random
  function automatic logic [127:0] lane_pattern(logic [1:0] sz);
    logic [127:0] v;
    logic [63:0]  p;
    int           w;
    w = 8 << sz;
    v = {rand64(), rand64()};
    for (int k = 0; k < 128 / w; k++) begin
      case ($urandom_range(0, 7))
        0: p = '0;
        1: p = 64'd1;
        2: p = '1;
        3: p = 64'd1 << (w - 1);
        4: p = ~(64'd1 << (w - 1));
        5: p = 64'd0 + $urandom_range(1, 9);
        default: p = rand64();
      endcase
      for (int b = 0; b < 64; b++) if (b < w) v[k*w + b] = p[b];
    end
    return v;
  endfunction

  task automatic send_word(pld_req_t rq);
    start <= 1'b1;
    req_i <= rq;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sent++;
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
        ($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  initial begin
    pld_req_t     rq;
    logic [127:0] x;
    logic [127:0] y;
    int           wait_cycles;
    sent = 0;
    idle_cycles = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // min over minus one, zero divisors, all-ones, every size and mode
    for (int s = 0; s < 4; s++) begin
      for (int m = 0; m < 4; m++) begin
        rq.action = m[0];
        rq.is_signed = m[1];
        rq.lane_size = s[1:0];
        case (m)
          0: begin x = '1; y = '0; end
          1: begin x = {rand64(), rand64()}; y = '1; end
          2: begin x = lane_pattern(s[1:0]); y = lane_pattern(s[1:0]); end
          default: begin x = {16{8'h80}}; y = {rand64(), rand64()}; end
        endcase
        if (m == 2 && s == 3) begin x = {64'h8000000000000000, 64'h8000000000000000};
          y = '1; end
        {rq.dividend_hi, rq.dividend_lo} = x;
        {rq.divisor_hi, rq.divisor_lo} = y;
        send_word(rq);
      end
    end
    for (int s = 0; s < 4; s++) begin
      rq.action = s[0];
      rq.is_signed = 1'b1;
      rq.lane_size = s[1:0];
      x = lane_pattern(s[1:0]);
      {rq.dividend_hi, rq.dividend_lo} = {16{8'h80}};
      {rq.divisor_hi, rq.divisor_lo} = '1;
      send_word(rq);
      rq.action = ~s[0];
      {rq.dividend_hi, rq.dividend_lo} = x;
      {rq.divisor_hi, rq.divisor_lo} = ~x;
      send_word(rq);
    end

    repeat (700) begin
      rq.action = 1'($urandom_range(0, 1));
      rq.is_signed = 1'($urandom_range(0, 1));
      rq.lane_size = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 3) == 0) begin
        x = {rand64(), rand64()};
        y = {rand64(), rand64()} >> $urandom_range(0, 127);
      end else begin
        x = lane_pattern(rq.lane_size);
        y = lane_pattern(rq.lane_size);
      end
      {rq.dividend_hi, rq.dividend_lo} = x;
      {rq.divisor_hi, rq.divisor_lo} = y;
      send_word(rq);
      idle_gap();
    end
    start <= 1'b0;

    wait_cycles = 0;
    while (pending_count != 0 && wait_cycles < 20 * Latency) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (Latency + 5) @(posedge clk_i);

    $display("sent %0d words over all lane sizes, signed and unsigned, quotient and remainder",
             sent);
    $display("including zero divisors and signed minimum over minus one lanes");
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
